// ===== sv/ripc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the ripple intro pixel color block.
package ripc_pkg;

    localparam int unsigned MAX_STRIP  = 128;
    localparam int unsigned GLOW_LEDS  = 6;
    localparam int unsigned STEPS      = 5;
    localparam int unsigned FRAMES_ALL = 30;
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned HUE_WRAP   = 360;
    localparam int unsigned HUE_SECTOR = 60;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MAIN_HUE        = 3'd0;
    localparam logic [2:0] REG_MAIN_SATURATION = 3'd1;
    localparam logic [2:0] REG_BACKLIGHT_LEVEL = 3'd2;
    localparam logic [2:0] REG_GLOW_HUE        = 3'd3;
    localparam logic [2:0] REG_GLOW_SATURATION = 3'd4;
    localparam logic [2:0] REG_GLOW_LEVEL      = 3'd5;
    localparam logic [2:0] REG_ENABLE_FLAGS    = 3'd6;
    localparam logic [2:0] REG_STRIP_LENGTH    = 3'd7;

    // Ring codes of the underglow pairs
    localparam logic [1:0] RING_CENTER = 2'd0;
    localparam logic [1:0] RING_MID    = 2'd1;
    localparam logic [1:0] RING_OUTER  = 2'd2;

    typedef struct packed {
        logic [4:0] frame_number;
        logic [6:0] pixel_index;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       sent;
        logic       finished;
    } pix_out_t;

    typedef struct packed {
        logic [8:0] main_hue;
        logic [6:0] main_saturation;
        logic [6:0] backlight_level;
        logic [8:0] glow_hue;
        logic [6:0] glow_saturation;
        logic [6:0] glow_level;
        logic [2:0] enable_flags;
        logic [7:0] strip_length;
    } cfg_t;

    // Decoded pixel: percent, level multiplier (0..5), wrapped hue, clamped saturation
    typedef struct packed {
        logic [6:0] pct;
        logic [2:0] lvl;
        logic [8:0] hue;
        logic [6:0] sat;
        logic       sent;
        logic       finished;
    } dec_t;

    function automatic logic [6:0] clamp_pct(input logic [6:0] v);
        return (v > 7'(PCT_FULL)) ? 7'(PCT_FULL) : v;
    endfunction

    function automatic logic [1:0] ring_of(input logic [2:0] pix);
        logic [1:0] r;
        unique case (pix)
            3'd0, 3'd5: r = RING_OUTER;
            3'd1, 3'd4: r = RING_MID;
            default:    r = RING_CENTER;
        endcase
        return r;
    endfunction

    // Percent (0..100) to 0..255 scale: floor(x*255/100) via reciprocal multiply
    function automatic logic [7:0] pct_to_8(input logic [6:0] x);
        logic [31:0] prod;
        prod = ((32'(x) << 8) - 32'(x)) * 32'd5243;
        return prod[26:19];
    endfunction

    // floor(x/255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// ===== sv/ripc_decode.sv =====
// Input stage: frame/pixel decode into brightness percent, level, hue and saturation.
module ripc_decode
    import ripc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pix_in_t in_data,
    output logic    dec_valid,
    input  logic    dec_ready,
    output dec_t    dec
);

    logic       valid_reg;
    dec_t       dec_reg;
    dec_t       dec_next;
    logic [8:0] frame_x13;
    logic [2:0] phase;
    logic [2:0] step;
    logic [2:0] fade;
    logic [1:0] ring;
    logic       killed;
    logic       is_glow;
    logic       sep;
    logic       bl_on;
    logic       ug_on;
    logic [2:0] lvl;
    logic [8:0] hue_raw;

    assign in_ready  = !valid_reg || dec_ready;
    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

    assign sep   = cfg.enable_flags[0];
    assign bl_on = cfg.enable_flags[1];
    assign ug_on = cfg.enable_flags[2];

    // frame/5 for frames below 32
    assign frame_x13 = 9'(in_data.frame_number) * 9'd13;
    assign phase     = frame_x13[8:6];
    assign step      = 3'(in_data.frame_number - 5'(phase) * 5'(STEPS)) + 3'd1;
    assign fade      = 3'(STEPS) - step;
    assign ring      = ring_of(in_data.pixel_index[2:0]);
    assign is_glow   = in_data.pixel_index < 7'(GLOW_LEDS);

    assign killed = (in_data.frame_number >= 5'(FRAMES_ALL))
                 || ({1'b0, in_data.pixel_index} >= cfg.strip_length)
                 || (cfg.strip_length > 8'(MAX_STRIP));

    always_comb
    begin
        lvl = 3'd0;
        if (is_glow)
        begin
            unique case (phase)
                3'd0: lvl = (ring == RING_CENTER) ? step : 3'd0;
                3'd1: lvl = (ring == RING_CENTER) ? fade :
                            ((ring == RING_MID) ? step : 3'd0);
                3'd2: lvl = (ring == RING_MID) ? fade :
                            ((ring == RING_OUTER) ? step : 3'd0);
                3'd3: lvl = (ring == RING_OUTER) ? fade :
                            ((ring == RING_MID) ? step : 3'd0);
                3'd4: lvl = (ring == RING_MID) ? fade :
                            ((ring == RING_CENTER) ? step : 3'd0);
                default:
                begin
                    if (ug_on)
                        lvl = (ring == RING_CENTER) ? 3'(STEPS) : step;
                    else
                        lvl = (ring == RING_CENTER) ? fade : 3'd0;
                end
            endcase
        end
        else if (bl_on && phase == 3'd4)
            lvl = step;
        else if (bl_on && phase >= 3'd5)
            lvl = 3'(STEPS);
    end

    always_comb
    begin
        hue_raw           = (is_glow && sep) ? cfg.glow_hue : cfg.main_hue;
        dec_next.pct      = clamp_pct(is_glow ? cfg.glow_level : cfg.backlight_level);
        dec_next.lvl      = killed ? 3'd0 : lvl;
        dec_next.hue      = (hue_raw >= 9'(HUE_WRAP)) ? hue_raw - 9'(HUE_WRAP) : hue_raw;
        dec_next.sat      = clamp_pct((is_glow && sep) ? cfg.glow_saturation
                                                       : cfg.main_saturation);
        dec_next.sent     = !killed;
        dec_next.finished = in_data.frame_number >= 5'(FRAMES_ALL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            dec_reg <= dec_next;
    end

endmodule

// ===== sv/ripc_hsb.sv =====
// HSB to RGB pipeline: brightness scale, sector split, products and channel select.
module ripc_hsb
    import ripc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     dec_valid,
    output logic     dec_ready,
    input  dec_t     dec,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    // stage 2
    logic        s2_valid_reg;
    logic        s2_ready;
    logic [6:0]  s2_bright_reg;
    logic [7:0]  s2_sat8_reg;
    logic [2:0]  s2_region_reg;
    logic [7:0]  s2_rem_reg;
    logic        s2_sent_reg;
    logic        s2_fin_reg;
    logic [16:0] bright_x205;
    logic [2:0]  region_next;
    logic [8:0]  hue_base;
    logic [5:0]  hue_mod;
    logic [9:0]  rem_x17;

    // stage 3
    logic        s3_valid_reg;
    logic        s3_ready;
    logic [7:0]  s3_v_reg;
    logic [7:0]  s3_one_s_reg;
    logic [7:0]  s3_sr_reg;
    logic [7:0]  s3_srn_reg;
    logic [2:0]  s3_region_reg;
    logic        s3_sent_reg;
    logic        s3_fin_reg;

    // output stage
    logic        out_valid_reg;
    logic        out_stage_ready;
    pix_out_t    out_reg;
    pix_out_t    out_next;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign out_stage_ready = !out_valid_reg || out_ready;
    assign s3_ready        = !s3_valid_reg || out_stage_ready;
    assign s2_ready        = !s2_valid_reg || s3_ready;
    assign dec_ready       = s2_ready;

    // stage 2: brightness percent = pct*lvl/5, hue sector and remainder
    assign bright_x205 = 17'(10'(dec.pct) * 10'(dec.lvl)) * 17'd205;

    always_comb
    begin
        priority if (dec.hue >= 9'(5 * HUE_SECTOR))
            region_next = 3'd5;
        else if (dec.hue >= 9'(4 * HUE_SECTOR))
            region_next = 3'd4;
        else if (dec.hue >= 9'(3 * HUE_SECTOR))
            region_next = 3'd3;
        else if (dec.hue >= 9'(2 * HUE_SECTOR))
            region_next = 3'd2;
        else if (dec.hue >= 9'(HUE_SECTOR))
            region_next = 3'd1;
        else
            region_next = 3'd0;
    end

    assign hue_base = 9'(region_next) * 9'(HUE_SECTOR);
    assign hue_mod  = 6'(dec.hue - hue_base);
    // 255/60 is exactly 17/4
    assign rem_x17  = 10'(hue_mod) * 10'd17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (dec_ready)
            s2_valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready && dec_valid)
        begin
            s2_bright_reg <= bright_x205[16:10];
            s2_sat8_reg   <= pct_to_8(dec.sat);
            s2_region_reg <= region_next;
            s2_rem_reg    <= rem_x17[9:2];
            s2_sent_reg   <= dec.sent;
            s2_fin_reg    <= dec.finished;
        end
    end

    // stage 3: value, saturation-weighted remainders
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_v_reg      <= pct_to_8(s2_bright_reg);
            s3_one_s_reg  <= 8'd255 - s2_sat8_reg;
            s3_sr_reg     <= div255(16'(s2_sat8_reg) * 16'(s2_rem_reg));
            s3_srn_reg    <= div255(16'(s2_sat8_reg) * 16'(8'd255 - s2_rem_reg));
            s3_region_reg <= s2_region_reg;
            s3_sent_reg   <= s2_sent_reg;
            s3_fin_reg    <= s2_fin_reg;
        end
    end

    // output stage: p, q, t products and channel select by sector
    assign p = div255(16'(s3_v_reg) * 16'(s3_one_s_reg));
    assign q = div255(16'(s3_v_reg) * 16'(8'd255 - s3_sr_reg));
    assign t = div255(16'(s3_v_reg) * 16'(8'd255 - s3_srn_reg));

    always_comb
    begin
        out_next.sent     = s3_sent_reg;
        out_next.finished = s3_fin_reg;
        unique case (s3_region_reg)
            3'd0:
            begin
                out_next.red = s3_v_reg; out_next.green = t; out_next.blue = p;
            end
            3'd1:
            begin
                out_next.red = q; out_next.green = s3_v_reg; out_next.blue = p;
            end
            3'd2:
            begin
                out_next.red = p; out_next.green = s3_v_reg; out_next.blue = t;
            end
            3'd3:
            begin
                out_next.red = p; out_next.green = q; out_next.blue = s3_v_reg;
            end
            3'd4:
            begin
                out_next.red = t; out_next.green = p; out_next.blue = s3_v_reg;
            end
            default:
            begin
                out_next.red = s3_v_reg; out_next.green = p; out_next.blue = q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_stage_ready)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && s3_valid_reg)
            out_reg <= out_next;
    end

endmodule

// ===== sv/ripple_intro_pixel_color_top.sv =====
// Top level of the ripple intro pixel color block: configuration registers and pipeline.
//
//   channel   direction   handshake                     payload
//   in        to block    in_valid / in_ready           in_data  (pix_in_t)
//   out       from block  out_valid / out_ready         out_data (pix_out_t)
//   cfg       to block    cfg_write (no wait)           cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; each pixel
// passes in order through the four register stages (decode, brightness/sector,
// value/remainders, products and channel select).
// Reset clears the valid bits and loads the configuration defaults.
// Each stage holds while the one after it is full and stalled, and takes
// a new transaction whenever it is empty, so bubbles close up under a stall.
module ripple_intro_pixel_color_top
    import ripc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data,
    input  logic     cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data
);

    cfg_t cfg_reg;
    logic dec_valid;
    logic dec_ready;
    dec_t dec;

    // Configuration registers; each write keeps only the register's own width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.main_hue        <= 9'd0;
            cfg_reg.main_saturation <= 7'd100;
            cfg_reg.backlight_level <= 7'd100;
            cfg_reg.glow_hue        <= 9'd0;
            cfg_reg.glow_saturation <= 7'd100;
            cfg_reg.glow_level      <= 7'd100;
            cfg_reg.enable_flags    <= 3'd6;
            cfg_reg.strip_length    <= 8'd6;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAIN_HUE:        cfg_reg.main_hue        <= cfg_data;
                REG_MAIN_SATURATION: cfg_reg.main_saturation <= cfg_data[6:0];
                REG_BACKLIGHT_LEVEL: cfg_reg.backlight_level <= cfg_data[6:0];
                REG_GLOW_HUE:        cfg_reg.glow_hue        <= cfg_data;
                REG_GLOW_SATURATION: cfg_reg.glow_saturation <= cfg_data[6:0];
                REG_GLOW_LEVEL:      cfg_reg.glow_level      <= cfg_data[6:0];
                REG_ENABLE_FLAGS:    cfg_reg.enable_flags    <= cfg_data[2:0];
                default:             cfg_reg.strip_length    <= cfg_data[7:0];
            endcase
        end
    end

    // Decode frame and pixel into percent, level, hue and saturation
    ripc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec)
    );

    // Convert to RGB over three more stages
    ripc_hsb u_hsb (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // A finished frame never carries a lit or sent pixel
    a_finished_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.finished |->
            !out_data.sent && out_data.red == 8'd0 && out_data.green == 8'd0
            && out_data.blue == 8'd0)
        else $error("finished pixel is not dark");

    // An unsent pixel is black
    a_unsent_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sent |->
            out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
        else $error("unsent pixel carries color");

    // With the output register empty, every stage must be able to advance
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");
`endif

endmodule
